[hdl/assert_macros.svh]
// assertion macros shared by the translator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/sc2a_pkg.sv]
// types, key constants and code tables of the scan code translator
`default_nettype none

package sc2a_pkg;

   localparam int CODE_W  = 8;
   localparam int IDX_W   = 7;
   localparam int SKIP_W  = 3;
   localparam int ROM_LEN = 89;

   localparam logic [CODE_W-1:0] EXT_PREFIX   = 8'hE0;
   localparam logic [CODE_W-1:0] PAUSE_PREFIX = 8'hE1;
   localparam logic [CODE_W-1:0] PAUSE_CODE   = 8'hA0;
   localparam logic [CODE_W-1:0] LETTER_FIRST = 8'h61;
   localparam logic [CODE_W-1:0] LETTER_LAST  = 8'h7A;

   localparam logic [IDX_W-1:0] LEFT_SHIFT    = 7'd42;
   localparam logic [IDX_W-1:0] RIGHT_SHIFT   = 7'd54;
   localparam logic [IDX_W-1:0] KEY_CAPS      = 7'd58;
   localparam logic [IDX_W-1:0] KEY_NUM       = 7'd69;
   localparam logic [IDX_W-1:0] KEY_SCROLL    = 7'd70;
   localparam logic [IDX_W-1:0] KEYPAD_FIRST  = 7'd71;
   localparam logic [IDX_W-1:0] KEYPAD_LAST   = 7'd83;
   localparam logic [IDX_W-1:0] SYMBOL_FIRST  = 7'd2;
   localparam logic [IDX_W-1:0] SYMBOL_LAST   = 7'd53;

   localparam logic [SKIP_W-1:0] PAUSE_SKIP_RESET = 3'd2;

   localparam logic [CODE_W-1:0] ROM_PLAIN [ROM_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
      8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

   localparam logic [CODE_W-1:0] ROM_SHIFTED [ROM_LEN] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic num_on;
      logic prefix_pending;
   } lock_state_type;

   typedef struct packed {
      logic              emitted;
      logic [CODE_W-1:0] key_code;
      logic              key_pressed;
      logic              extended_key;
      logic              led_update;
      logic              caps_led;
      logic              num_led;
      logic              scroll_led;
   } result_type;

endpackage

`default_nettype wire

[hdl/sc2a_channels.sv]
// valid/ready channel interfaces of the scan code translator
`default_nettype none

interface sc2a_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink (input valid, input scan_code, output ready);
endinterface

interface sc2a_rsp_if;
   logic       valid;
   logic       ready;
   logic       emitted;
   logic [7:0] key_code;
   logic       key_pressed;
   logic       extended_key;
   logic       led_update;
   logic       caps_led;
   logic       num_led;
   logic       scroll_led;

   modport source (
      output valid, output emitted, output key_code, output key_pressed,
      output extended_key, output led_update, output caps_led, output num_led,
      output scroll_led, input ready
   );
   modport sink (
      input valid, input emitted, input key_code, input key_pressed,
      input extended_key, input led_update, input caps_led, input num_led,
      input scroll_led, output ready
   );
endinterface

interface sc2a_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] pause_skip_count;

   modport source (output valid, output pause_skip_count, input ready);
   modport sink (input valid, input pause_skip_count, output ready);
endinterface

`default_nettype wire

[hdl/scan_code_to_ascii_translator_top.sv]
// top level of the set-1 scan code to key code translator
`default_nettype none
`include "assert_macros.svh"

// Translates one set-1 scan code byte per transaction into one result
// transaction carrying the key code, make/break and extended flags and the
// lock LED states. A byte is accepted every cycle while the result register
// is empty or being drained; its result is registered on accept. The rate is
// set by the single result register, which holds the table read and the lock
// state update done in the cycle of acceptance. The pause skip count is
// written through the csr channel, which is always ready; reset value is 2.

module scan_code_to_ascii_translator_top #(
   parameter int TABLE_ENTRIES = 89
) (
   input wire logic    clock,
   input wire logic    reset,
   sc2a_req_if.sink    req_port,
   sc2a_rsp_if.source  rsp_port,
   sc2a_csr_if.sink    csr_port
);

   logic                          req_accept;
   logic [sc2a_pkg::SKIP_W-1:0]   pause_skip_count_ff;
   logic                          shift_held_ff, shift_held_in;
   logic                          caps_on_ff, caps_on_in;
   logic                          num_on_ff, num_on_in;
   logic                          scroll_on_ff, scroll_on_in;
   logic                          prefix_pending_ff, prefix_pending_in;
   logic [sc2a_pkg::SKIP_W-1:0]   skip_left_ff, skip_left_in;
   logic                          rsp_valid_ff;
   sc2a_pkg::result_type          rsp_ff, rsp_in;
   sc2a_pkg::lock_state_type      lock_state;
   logic [sc2a_pkg::IDX_W-1:0]    key_index;
   logic                          key_make;
   logic [sc2a_pkg::CODE_W-1:0]   table_code;
   logic                          skip_accept;
   logic                          pause_accept;
   logic                          led_accept;
   logic [2:0]                    lock_bits;
   logic [2:0]                    rsp_leds;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_accept     = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   assign key_index = req_port.scan_code[sc2a_pkg::IDX_W-1:0];
   assign key_make  = !req_port.scan_code[sc2a_pkg::CODE_W-1];

   assign lock_state = '{
      shift_held:     shift_held_ff,
      caps_on:        caps_on_ff,
      num_on:         num_on_ff,
      prefix_pending: prefix_pending_ff
   };

   sc2a_lookup #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_lookup (
      .key_index  (key_index),
      .lock_state (lock_state),
      .key_code   (table_code)
   );

   always_comb begin
      shift_held_in     = shift_held_ff;
      caps_on_in        = caps_on_ff;
      num_on_in         = num_on_ff;
      scroll_on_in      = scroll_on_ff;
      prefix_pending_in = prefix_pending_ff;
      skip_left_in      = skip_left_ff;
      rsp_in            = '0;
      if (skip_left_ff != '0) begin
         skip_left_in = skip_left_ff - sc2a_pkg::SKIP_W'(1);
      end else if (req_port.scan_code == sc2a_pkg::PAUSE_PREFIX) begin
         rsp_in.emitted     = 1'b1;
         rsp_in.key_code    = sc2a_pkg::PAUSE_CODE;
         rsp_in.key_pressed = 1'b1;
         skip_left_in       = pause_skip_count_ff;
      end else if (req_port.scan_code == sc2a_pkg::EXT_PREFIX) begin
         prefix_pending_in = 1'b1;
      end else begin
         rsp_in.emitted      = 1'b1;
         rsp_in.key_code     = table_code;
         rsp_in.key_pressed  = key_make;
         rsp_in.extended_key = prefix_pending_ff;
         prefix_pending_in   = 1'b0;
         if (key_index == sc2a_pkg::LEFT_SHIFT || key_index == sc2a_pkg::RIGHT_SHIFT) begin
            shift_held_in = key_make;
         end else if (key_index == sc2a_pkg::KEY_CAPS && key_make) begin
            caps_on_in        = !caps_on_ff;
            rsp_in.led_update = 1'b1;
         end else if (key_index == sc2a_pkg::KEY_NUM && key_make) begin
            num_on_in         = !num_on_ff;
            rsp_in.led_update = 1'b1;
         end else if (key_index == sc2a_pkg::KEY_SCROLL && key_make) begin
            scroll_on_in      = !scroll_on_ff;
            rsp_in.led_update = 1'b1;
         end
      end
      rsp_in.caps_led   = caps_on_in;
      rsp_in.num_led    = num_on_in;
      rsp_in.scroll_led = scroll_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_skip_count_ff <= sc2a_pkg::PAUSE_SKIP_RESET;
      end else if (csr_port.valid && csr_port.ready) begin
         pause_skip_count_ff <= csr_port.pause_skip_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff     <= 1'b0;
         caps_on_ff        <= 1'b0;
         num_on_ff         <= 1'b0;
         scroll_on_ff      <= 1'b0;
         prefix_pending_ff <= 1'b0;
         skip_left_ff      <= '0;
      end else if (req_accept) begin
         shift_held_ff     <= shift_held_in;
         caps_on_ff        <= caps_on_in;
         num_on_ff         <= num_on_in;
         scroll_on_ff      <= scroll_on_in;
         prefix_pending_ff <= prefix_pending_in;
         skip_left_ff      <= skip_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.emitted      = rsp_ff.emitted;
   assign rsp_port.key_code     = rsp_ff.key_code;
   assign rsp_port.key_pressed  = rsp_ff.key_pressed;
   assign rsp_port.extended_key = rsp_ff.extended_key;
   assign rsp_port.led_update   = rsp_ff.led_update;
   assign rsp_port.caps_led     = rsp_ff.caps_led;
   assign rsp_port.num_led      = rsp_ff.num_led;
   assign rsp_port.scroll_led   = rsp_ff.scroll_led;

   assign skip_accept  = req_accept && (skip_left_ff != '0);
   assign pause_accept = req_accept && (skip_left_ff == '0)
                         && (req_port.scan_code == sc2a_pkg::PAUSE_PREFIX);
   assign led_accept   = req_accept && rsp_in.led_update;
   assign lock_bits    = {caps_on_ff, num_on_ff, scroll_on_ff};
   assign rsp_leds     = {rsp_ff.caps_led, rsp_ff.num_led, rsp_ff.scroll_led};

   `ASSERT_NEXT(a_skip_silent, clock, reset, skip_accept, !rsp_ff.emitted && !rsp_ff.led_update)
   `ASSERT_NEXT(a_pause_load, clock, reset, pause_accept, skip_left_ff == $past(pause_skip_count_ff))
   `ASSERT_NEXT(a_led_toggle, clock, reset, led_accept, lock_bits != $past(lock_bits))
   `ASSERT_NEXT(a_ext_prefix, clock, reset, req_accept && !prefix_pending_ff, !rsp_ff.extended_key)
   `ASSERT_IMPLIES(a_led_mirror, clock, reset, rsp_valid_ff, rsp_leds == lock_bits)

endmodule

`default_nettype wire

[hdl/sc2a_lookup.sv]
// two-column key code table read with shift, caps and num lock column select
`default_nettype none

module sc2a_lookup #(
   parameter int TABLE_ENTRIES = 89
) (
   input  wire logic [sc2a_pkg::IDX_W-1:0]  key_index,
   input  wire sc2a_pkg::lock_state_type    lock_state,
   output logic      [sc2a_pkg::CODE_W-1:0] key_code
);

   logic                          in_range;
   logic [sc2a_pkg::CODE_W-1:0]   plain_code;
   logic [sc2a_pkg::CODE_W-1:0]   shifted_code;
   logic                          use_shifted;

   always_comb begin
      in_range     = (int'(key_index) < TABLE_ENTRIES) && (int'(key_index) < sc2a_pkg::ROM_LEN);
      plain_code   = in_range ? sc2a_pkg::ROM_PLAIN[key_index] : '0;
      shifted_code = in_range ? sc2a_pkg::ROM_SHIFTED[key_index] : '0;
      if (plain_code inside {[sc2a_pkg::LETTER_FIRST:sc2a_pkg::LETTER_LAST]}) begin
         use_shifted = lock_state.shift_held ^ lock_state.caps_on;
      end else if (key_index inside {[sc2a_pkg::SYMBOL_FIRST:sc2a_pkg::SYMBOL_LAST]}) begin
         use_shifted = lock_state.shift_held;
      end else if ((key_index inside {[sc2a_pkg::KEYPAD_FIRST:sc2a_pkg::KEYPAD_LAST]})
                   && !lock_state.prefix_pending) begin
         use_shifted = lock_state.num_on;
      end else begin
         use_shifted = 1'b0;
      end
      key_code = use_shifted ? shifted_code : plain_code;
   end

endmodule

`default_nettype wire

[tb/sc2a_checker.sv]
// scan code translator checker: predicts each result and compares it with the block's output
`default_nettype none

module sc2a_checker
   import sc2a_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sc2a_req_if       req_mon,
   sc2a_rsp_if       rsp_mon,
   sc2a_csr_if       csr_mon,
   output int        mismatch_count,
   output int        results_pending,
   output int        results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] PLAIN_COL [ROM_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h93, 8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
      8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

   localparam logic [7:0] SHIFT_COL [ROM_LEN] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A, 8'h85, 8'h20, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91,
      8'h92, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E, 8'h9F
   };

   logic [2:0]  skip_setting;
   logic        shift_down;
   logic        caps_lock;
   logic        num_lock;
   logic        scroll_lock;
   logic        ext_pending;
   logic [2:0]  bytes_to_skip;
   result_type  expected_keys [$];

   function automatic logic [7:0] table_code(input logic [6:0] idx, input logic shifted);
      if (idx >= ROM_LEN) return 8'h00;
      return shifted ? SHIFT_COL[idx] : PLAIN_COL[idx];
   endfunction

   function automatic result_type translate_scan(input logic [7:0] code);
      result_type r;
      logic [6:0] idx;
      logic [7:0] plain;
      logic       use_shift;
      r = '0;
      idx = code[6:0];
      if (bytes_to_skip != 3'd0) begin
         bytes_to_skip = bytes_to_skip - 3'd1;
      end else if (code == PAUSE_PREFIX) begin
         r.emitted = 1'b1;
         r.key_code = PAUSE_CODE;
         r.key_pressed = 1'b1;
         bytes_to_skip = skip_setting;
      end else if (code == EXT_PREFIX) begin
         ext_pending = 1'b1;
      end else begin
         plain = table_code(idx, 1'b0);
         if (plain >= LETTER_FIRST && plain <= LETTER_LAST) begin
            use_shift = shift_down ^ caps_lock;
         end else if (idx >= SYMBOL_FIRST && idx <= SYMBOL_LAST) begin
            use_shift = shift_down;
         end else if (idx >= KEYPAD_FIRST && idx <= KEYPAD_LAST && !ext_pending) begin
            use_shift = num_lock;
         end else begin
            use_shift = 1'b0;
         end
         r.emitted = 1'b1;
         r.key_code = table_code(idx, use_shift);
         r.extended_key = ext_pending;
         ext_pending = 1'b0;
         r.key_pressed = ~code[7];
         if (idx == LEFT_SHIFT || idx == RIGHT_SHIFT) begin
            shift_down = r.key_pressed;
         end else if (idx == KEY_CAPS && r.key_pressed) begin
            caps_lock = ~caps_lock;
            r.led_update = 1'b1;
         end else if (idx == KEY_NUM && r.key_pressed) begin
            num_lock = ~num_lock;
            r.led_update = 1'b1;
         end else if (idx == KEY_SCROLL && r.key_pressed) begin
            scroll_lock = ~scroll_lock;
            r.led_update = 1'b1;
         end
      end
      r.caps_led = caps_lock;
      r.num_led = num_lock;
      r.scroll_led = scroll_lock;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         skip_setting = PAUSE_SKIP_RESET;
         shift_down = 1'b0;
         caps_lock = 1'b0;
         num_lock = 1'b0;
         scroll_lock = 1'b0;
         ext_pending = 1'b0;
         bytes_to_skip = 3'd0;
         expected_keys.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            skip_setting = csr_mon.pause_skip_count;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_keys.push_back(translate_scan(req_mon.scan_code));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_keys.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual key 0x%02h",
                        $time, rsp_mon.key_code);
               mismatch_count++;
            end else begin
               want = expected_keys.pop_front();
               results_checked++;
               check_field("emitted", 8'(want.emitted), 8'(rsp_mon.emitted));
               check_field("key_code", want.key_code, rsp_mon.key_code);
               check_field("key_pressed", 8'(want.key_pressed), 8'(rsp_mon.key_pressed));
               check_field("extended_key", 8'(want.extended_key), 8'(rsp_mon.extended_key));
               check_field("led_update", 8'(want.led_update), 8'(rsp_mon.led_update));
               check_field("caps_led", 8'(want.caps_led), 8'(rsp_mon.caps_led));
               check_field("num_led", 8'(want.num_led), 8'(rsp_mon.num_led));
               check_field("scroll_led", 8'(want.scroll_led), 8'(rsp_mon.scroll_led));
            end
         end
      end
      results_pending = expected_keys.size();
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench top of the scan code translator: stimulus, pause skip settings and verdict
`default_nettype none

module tb_top;
   import sc2a_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_ITEMS  = 250;
   localparam int PHASES       = 6;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset;
   bit   quiet;
   bit   long_hold_pending;
   int   sent_count;
   int   mismatch_count;
   int   results_pending;
   int   results_checked;
   logic [2:0] skip_now;

   sc2a_req_if req_ch ();
   sc2a_rsp_if rsp_ch ();
   sc2a_csr_if csr_ch ();

   scan_code_to_ascii_translator_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   sc2a_checker key_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_mon         (csr_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", results_pending);
      $display("status: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_ch.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_scan(input logic [7:0] code);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.scan_code <= code;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic write_skip_count(input logic [2:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.pause_skip_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      skip_now = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_sequence();
      logic [6:0] idx;
      logic [6:0] other;
      bit         prefixed;
      int         n;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            idx = 7'($urandom_range(1, ROM_LEN - 1));
            prefixed = ($urandom_range(0, 3) == 0);
            if (prefixed) send_scan(EXT_PREFIX);
            send_scan({1'b0, idx});
            if ($urandom_range(0, 3) != 0) begin
               if (prefixed) send_scan(EXT_PREFIX);
               send_scan({1'b1, idx});
            end
         end
         3: begin
            idx = $urandom_range(0, 1) ? LEFT_SHIFT : RIGHT_SHIFT;
            other = $urandom_range(0, 1) ? LEFT_SHIFT : RIGHT_SHIFT;
            send_scan({1'b0, idx});
            n = $urandom_range(1, 6);
            repeat (n) send_scan({1'b0, 7'($urandom_range(SYMBOL_FIRST, SYMBOL_LAST))});
            send_scan({1'b1, other});
         end
         4: begin
            case ($urandom_range(0, 2))
               0: idx = KEY_CAPS;
               1: idx = KEY_NUM;
               default: idx = KEY_SCROLL;
            endcase
            if ($urandom_range(0, 3) == 0) send_scan(EXT_PREFIX);
            send_scan({1'b0, idx});
            if ($urandom_range(0, 2) != 0) send_scan({1'b1, idx});
         end
         5: begin
            idx = 7'($urandom_range(KEYPAD_FIRST, KEYPAD_LAST));
            if ($urandom_range(0, 2) == 0) send_scan(EXT_PREFIX);
            send_scan({1'b0, idx});
            send_scan({1'b1, idx});
         end
         6: begin
            send_scan(PAUSE_PREFIX);
            repeat (skip_now) send_scan(8'($urandom_range(0, 255)));
         end
         7: begin
            idx = 7'($urandom_range(ROM_LEN, 127));
            send_scan({$urandom_range(0, 1) == 1, idx});
         end
         default: begin
            send_scan(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      logic [7:0] directed_bytes [25];
      logic [2:0] skip_plan [PHASES];
      int         target;
      directed_bytes = '{
         8'h1E, 8'h9E,
         {1'b0, LEFT_SHIFT}, 8'h1E, 8'h02, {1'b1, LEFT_SHIFT},
         {1'b0, KEY_CAPS}, {1'b1, KEY_CAPS}, 8'h1E,
         {1'b0, RIGHT_SHIFT}, 8'h1E, {1'b0, LEFT_SHIFT}, {1'b1, RIGHT_SHIFT}, 8'h1E,
         {1'b0, KEY_NUM}, {1'b0, KEYPAD_FIRST}, EXT_PREFIX, {1'b0, KEYPAD_FIRST},
         EXT_PREFIX, {1'b0, KEY_SCROLL},
         PAUSE_PREFIX, EXT_PREFIX, PAUSE_PREFIX,
         8'h7F, 8'hFF
      };
      skip_plan = '{3'd7, 3'd0, 3'($urandom_range(0, 7)), 3'd5, 3'($urandom_range(0, 7)), 3'd1};
      reset = 1'b1;
      quiet = 1'b0;
      long_hold_pending = 1'b0;
      skip_now = PAUSE_SKIP_RESET;
      req_ch.valid = 1'b0;
      req_ch.scan_code = 8'h00;
      csr_ch.valid = 1'b0;
      csr_ch.pause_skip_count = 3'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_bytes[i]) send_scan(directed_bytes[i]);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         write_skip_count(skip_plan[p]);
         if (p == 1) long_hold_pending = 1'b1;
         if (p == PHASES - 1) quiet = 1'b1;
         target = sent_count + PHASE_ITEMS;
         while (sent_count < target) random_sequence();
         drain_results();
      end

      $display("sent %0d scan bytes and checked %0d results over %0d pause skip settings",
               sent_count, results_checked, PHASES + 1);
      $display("settings included 0 and 7, with one %0d-cycle result stall", LONG_HOLD);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
